[rtl/ssw_pkg.sv]
package ssw_pkg;

	// Default width of table offsets
	localparam int OFFSET_BITS_DEF = 32;

	// Header is type, length and two handle bytes
	localparam int unsigned HEADER_BYTES = 4;
	localparam logic [7:0] END_OF_TABLE_TYPE = 8'd127;

	// Configuration port
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	typedef enum logic [1:0] {
		REG_COUNT_MODE   = 2'd0,
		REG_STRUCT_LIMIT = 2'd1,
		REG_TABLE_LENGTH = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic        count_mode;
		logic [15:0] structure_limit;
		logic [31:0] table_length;
	} cfg_t;

	typedef struct packed {
		logic        found;
		logic [7:0]  stype;
		logic [7:0]  slength;
		logic [15:0] handle;
		logic [31:0] offset;
		logic [15:0] index;
		logic        short_hdr;
		logic        walk_end;
	} res_t;

endpackage

[rtl/ssw_cfg_regs.sv]
module ssw_cfg_regs
	import ssw_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output cfg_t                     cfg
);

	reg_idx_t reg_idx;
	logic     wr_en;
	cfg_t     cfg_q;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_COUNT_MODE: begin
					cfg_q.count_mode <= pwdata[0];
				end
				REG_STRUCT_LIMIT: begin
					cfg_q.structure_limit <= pwdata[15:0];
				end
				REG_TABLE_LENGTH: begin
					cfg_q.table_length <= pwdata[31:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (reg_idx)
			REG_COUNT_MODE:   prdata = {31'd0, cfg_q.count_mode};
			REG_STRUCT_LIMIT: prdata = {16'd0, cfg_q.structure_limit};
			REG_TABLE_LENGTH: prdata = cfg_q.table_length;
			default:          prdata = '0;
		endcase
	end

endmodule

[rtl/ssw_walk_core.sv]
module ssw_walk_core
	import ssw_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] table_byte,
	input  logic       first_byte,
	input  cfg_t       cfg,
	output logic       res_valid,
	output res_t       res
);

	localparam int OB = OFFSET_BITS;
	localparam logic [32:0] CAP = (33'd1 << OB) - 33'd1;

	// Walk state
	logic [OB-1:0] offs_q, start_q;
	logic [OB:0]   scan_q;
	logic [2:0]    hidx_q;
	logic [7:0]    type_q, hlen_q;
	logic [15:0]   handle_q;
	logic          pz_q;
	logic [15:0]   done_q;
	logic          active_q;

	// State after a possible restart
	logic [OB-1:0] e_offs, e_start;
	logic [OB:0]   e_scan;
	logic [2:0]    e_hidx;
	logic [7:0]    e_type, e_hlen;
	logic [15:0]   e_handle;
	logic          e_pz;
	logic [15:0]   e_done;
	logic          e_active;

	// Next state
	logic [OB-1:0] n_offs, n_start;
	logic [OB:0]   n_scan;
	logic [2:0]    n_hidx;
	logic [7:0]    n_type, n_hlen;
	logic [15:0]   n_handle;
	logic          n_pz;
	logic [15:0]   n_done;
	logic          n_active;

	logic [OB-1:0] len;
	logic          empty, proceed, found, miss, is_end;
	logic [OB-1:0] o, nxt;
	logic [OB:0]   o_m1, from;
	logic [15:0]   done_inc;

	// Usable length, capped to the offset range
	assign len = ({1'b0, cfg.table_length} > CAP) ? CAP[OB-1:0] : cfg.table_length[OB-1:0];

	// Restart on a first byte
	always_comb begin
		e_offs   = first_byte ? '0 : offs_q;
		e_start  = first_byte ? '0 : start_q;
		e_scan   = first_byte ? '0 : scan_q;
		e_hidx   = first_byte ? '0 : hidx_q;
		e_type   = first_byte ? '0 : type_q;
		e_hlen   = first_byte ? '0 : hlen_q;
		e_handle = first_byte ? '0 : handle_q;
		e_pz     = first_byte ? 1'b0 : pz_q;
		e_done   = first_byte ? '0 : done_q;
		e_active = first_byte ? 1'b1 : active_q;
	end

	assign empty    = first_byte & ((cfg.count_mode & (cfg.structure_limit == 16'd0)) |
		({1'b0, len} < (OB+1)'(HEADER_BYTES)));
	assign proceed  = e_active & ~empty & (e_offs < len);
	assign o        = e_offs;
	assign nxt      = o + OB'(1);
	assign o_m1     = {1'b0, o} - (OB+1)'(1);
	assign done_inc = e_done + 16'd1;

	// Header capture, terminator search and end detection
	always_comb begin
		n_offs   = e_offs;
		n_start  = e_start;
		n_scan   = e_scan;
		n_hidx   = e_hidx;
		n_type   = e_type;
		n_hlen   = e_hlen;
		n_handle = e_handle;
		n_pz     = e_pz;
		n_done   = e_done;
		n_active = e_active & ~empty;
		found    = 1'b0;
		miss     = 1'b0;
		is_end   = 1'b0;
		from     = '0;
		if (proceed) begin
			n_offs = nxt;
			case (e_hidx)
				3'd0: n_type = table_byte;
				3'd1: begin
					n_hlen = table_byte;
					n_scan = {1'b0, e_start} + {{(OB-7){1'b0}}, table_byte};
				end
				3'd2: n_handle = {8'd0, table_byte};
				3'd3: n_handle = {table_byte, e_handle[7:0]};
				default: begin
				end
			endcase
			if (e_hidx < 3'(HEADER_BYTES))
				n_hidx = e_hidx + 3'd1;
			found = (n_hidx >= 3'd2) & (o != '0) & (o_m1 >= n_scan) & e_pz &
				(table_byte == 8'd0);
			n_pz = (table_byte == 8'd0);
			from = (n_scan > {1'b0, o}) ? n_scan : {1'b0, o};
			if (found) begin
				is_end = (cfg.count_mode & (done_inc >= cfg.structure_limit)) |
					(({2'b0, nxt} + (OB+2)'(HEADER_BYTES)) > {2'b0, len}) |
					(~cfg.count_mode & (n_type == END_OF_TABLE_TYPE));
			end else if (n_hidx == 3'(HEADER_BYTES)) begin
				miss = ({1'b0, from} + (OB+2)'(2)) > {2'b0, len};
			end
		end
	end

	// Result record
	always_comb begin
		res_valid = empty | found | miss;
		if (empty) begin
			res          = '0;
			res.walk_end = 1'b1;
		end else begin
			res.found     = found;
			res.stype     = n_type;
			res.slength   = n_hlen;
			res.handle    = n_handle;
			res.offset    = 32'(e_start);
			res.index     = e_done;
			res.short_hdr = (n_hlen < 8'(HEADER_BYTES));
			res.walk_end  = is_end | miss;
		end
	end

	// State update per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offs_q   <= '0;
			start_q  <= '0;
			scan_q   <= '0;
			hidx_q   <= '0;
			type_q   <= '0;
			hlen_q   <= '0;
			handle_q <= '0;
			pz_q     <= 1'b0;
			done_q   <= '0;
			active_q <= 1'b0;
		end else if (advance) begin
			offs_q <= n_offs;
			pz_q   <= n_pz;
			if (found) begin
				// next header follows the double zero
				start_q  <= nxt;
				scan_q   <= {1'b0, nxt};
				hidx_q   <= '0;
				type_q   <= '0;
				hlen_q   <= '0;
				handle_q <= '0;
				done_q   <= done_inc;
				active_q <= ~is_end;
			end else begin
				start_q  <= n_start;
				scan_q   <= n_scan;
				hidx_q   <= n_hidx;
				type_q   <= n_type;
				hlen_q   <= n_hlen;
				handle_q <= n_handle;
				done_q   <= n_done;
				active_q <= n_active & ~miss;
			end
		end
	end

endmodule

[rtl/smbios_structure_walker.sv]
// SMBIOS structure table walker. Table bytes enter on the s_ stream, one per
// beat, with s_tuser set on the byte at offset zero to restart a walk. Each
// structure found gives one m_ beat with its header fields; the beat that ends
// the walk has m_tlast set, and m_tuser[0] clear if no terminator was seen.
// A byte is taken every cycle unless the output stalls: it lands in an input
// register, passes through one stage of compare and counter logic against the
// walk state, and the record lands in the output register. Program count_mode,
// structure_limit and table_length over the APB port (addresses 0x0, 0x4, 0x8)
// while no walk is in progress. OFFSET_BITS sets the width of the offset
// counters.
module smbios_structure_walker
	import ssw_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [7:0]               s_tdata,  // [7:0] table_byte
	input  logic                     s_tuser,  // [0] first_byte
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// [7:0] struct_type, [15:8] struct_length, [31:16] struct_handle,
	// [63:32] struct_offset, [79:64] struct_index
	output logic [79:0]              m_tdata,
	output logic [1:0]               m_tuser,  // [0] struct_found, [1] short_header
	output logic                     m_tlast,  // walk_end
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	cfg_t       cfg;
	res_t       res;
	logic       res_valid;
	logic       valid_s1, first_s1;
	logic [7:0] byte_s1;
	logic       advance;
	res_t       out_q;

	ssw_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// Stage moves when the output register has room
	assign advance  = valid_s1 & (~m_tvalid | m_tready);
	assign s_tready = ~valid_s1 | advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	ssw_walk_core #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.table_byte(byte_s1),
		.first_byte(first_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance && res_valid) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid)
			out_q <= res;
	end

	assign m_tdata = {out_q.index, out_q.offset, out_q.handle, out_q.slength, out_q.stype};
	assign m_tuser = {out_q.short_hdr, out_q.found};
	assign m_tlast = out_q.walk_end;

	// A record without terminator always ends the walk
	a_miss_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast)
		else $error("record without terminator does not end walk");

	// A held byte is not dropped while the output stalls
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("stalled input byte lost");

	// A new record never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("waiting record overwritten");

endmodule

[verif/smbios_structure_walker_tb.sv]
`timescale 1ns / 100ps

module smbios_structure_walker_tb;
	import ssw_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;

	// Directed walk: short header with terminator in the header, a full-range
	// structure, then end-of-table
	localparam logic [7:0] MIXED_WALK [16] = '{
		8'h00, 8'h00,
		8'hFF, 8'h05, 8'hFF, 8'hFF, 8'hFF, 8'h41, 8'h00, 8'h00,
		8'h7F, 8'h04, 8'h34, 8'h12, 8'h00, 8'h00
	};
	// Directed walk: terminator cannot fit before the table end
	localparam logic [7:0] CUT_WALK [6] = '{
		8'h01, 8'h04, 8'h11, 8'h22, 8'h41, 8'h42
	};

	typedef struct packed {
		logic       first;
		logic [7:0] data;
	} table_beat_t;

	logic clk;
	logic arst_n;

	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;  // [7:0] table_byte
	logic        s_tuser = 1'b0;  // [0] first_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [7:0] struct_type, [15:8] struct_length, [31:16] struct_handle,
	// [63:32] struct_offset, [79:64] struct_index
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;  // [0] struct_found, [1] short_header
	logic        m_tlast;

	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [APB_DATA_BITS-1:0] pwdata = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	// Stimulus and scoreboard
	table_beat_t table_beats[$];
	res_t        struct_records_due[$];
	bit          beat_taken = 1'b0;
	bit          mismatch_seen = 1'b0;
	int          src_idle_pct = 0;
	int          sink_stall_pct = 0;
	int          beats_queued = 0;

	// Shadow registers
	logic        cfg_mode = 1'b0;
	logic [15:0] cfg_limit = '0;
	logic [31:0] cfg_tlen = '0;

	// Walk state
	longint unsigned next_off = 0;
	longint unsigned hdr_off = 0;
	longint unsigned scan_from = 0;
	int              hdr_cnt = 0;
	logic [7:0]      h_type = '0;
	logic [7:0]      h_len = '0;
	logic [15:0]     h_handle = '0;
	bit              prev_zero = 1'b0;
	logic [15:0]     done_cnt = '0;
	bit              walk_on = 1'b0;

	smbios_structure_walker uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void open_structure(input longint unsigned at);
		hdr_off = at;
		scan_from = at;
		hdr_cnt = 0;
		h_type = '0;
		h_len = '0;
		h_handle = '0;
	endfunction

	function automatic res_t structure_record(input bit found, input bit fin);
		res_t r;
		r.found = found;
		r.stype = h_type;
		r.slength = h_len;
		r.handle = h_handle;
		r.offset = hdr_off[31:0];
		r.index = done_cnt;
		r.short_hdr = (h_len < HEADER_BYTES);
		r.walk_end = fin;
		return r;
	endfunction

	// Advance the walk by one table byte; returns 1 when a record comes out
	function automatic bit walk_step(input logic [7:0] b, input logic first, output res_t rec);
		longint unsigned len;
		longint unsigned o;
		longint unsigned nxt;
		longint unsigned from;
		bit hit;
		bit fin;
		// 32-bit register already sits at or below the offset cap
		len = longint'(cfg_tlen);
		rec = '0;
		hit = 1'b0;
		fin = 1'b0;
		if (first) begin
			next_off = 0;
			open_structure(0);
			prev_zero = 1'b0;
			done_cnt = '0;
			walk_on = 1'b1;
			// empty walk: nothing to find
			if ((cfg_mode && cfg_limit == 16'd0) || len < HEADER_BYTES) begin
				walk_on = 1'b0;
				rec.walk_end = 1'b1;
				return 1'b1;
			end
		end
		if (!walk_on || next_off >= len)
			return 1'b0;
		o = next_off;
		next_off = o + 1;

		// header capture
		if (hdr_cnt < HEADER_BYTES) begin
			case (hdr_cnt)
				0: h_type = b;
				1: begin
					h_len = b;
					scan_from = hdr_off + b;
				end
				2: h_handle = {8'h00, b};
				default: h_handle[15:8] = b;
			endcase
			hdr_cnt++;
		end

		// double zero at or after start plus length
		if (hdr_cnt >= 2 && o >= 1 && o - 1 >= scan_from && prev_zero && b == 8'h00)
			hit = 1'b1;
		prev_zero = (b == 8'h00);

		if (hit) begin
			nxt = o + 1;
			if (cfg_mode && 16'(done_cnt + 16'd1) >= cfg_limit)
				fin = 1'b1;
			if (nxt + HEADER_BYTES > len)
				fin = 1'b1;
			if (!cfg_mode && h_type == END_OF_TABLE_TYPE)
				fin = 1'b1;
			rec = structure_record(1'b1, fin);
			done_cnt = done_cnt + 16'd1;
			open_structure(nxt);
			if (fin)
				walk_on = 1'b0;
			return 1'b1;
		end

		// no pair can still fit inside the table
		if (hdr_cnt == HEADER_BYTES) begin
			from = (scan_from > o) ? scan_from : o;
			if (from + 2 > len) begin
				rec = structure_record(1'b0, 1'b1);
				walk_on = 1'b0;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_seen = 1'b1;
		end
	endtask

	// Input beats feed the walk state, output beats are checked in order
	always @(posedge clk) begin
		res_t rec;
		if (arst_n) begin
			beat_taken = s_tvalid && s_tready;
			if (beat_taken) begin
				if (walk_step(s_tdata, s_tuser, rec))
					struct_records_due.push_back(rec);
			end
			if (m_tvalid && m_tready) begin
				if (struct_records_due.size() == 0) begin
					$error("record with none due: m_tdata %h m_tuser %b m_tlast %b",
						m_tdata, m_tuser, m_tlast);
					mismatch_seen = 1'b1;
				end else begin
					rec = struct_records_due.pop_front();
					check_field("struct_found", 32'(rec.found), 32'(m_tuser[0]));
					check_field("struct_type", 32'(rec.stype), 32'(m_tdata[7:0]));
					check_field("struct_length", 32'(rec.slength), 32'(m_tdata[15:8]));
					check_field("struct_handle", 32'(rec.handle), 32'(m_tdata[31:16]));
					check_field("struct_offset", rec.offset, m_tdata[63:32]);
					check_field("struct_index", 32'(rec.index), 32'(m_tdata[79:64]));
					check_field("short_header", 32'(rec.short_hdr), 32'(m_tuser[1]));
					check_field("walk_end", 32'(rec.walk_end), 32'(m_tlast));
				end
			end
		end
	end

	// Table byte source and record sink
	always @(negedge clk) begin
		table_beat_t beat;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			if (!s_tvalid || beat_taken) begin
				if (table_beats.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					beat = table_beats.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= beat.data;
					s_tuser <= beat.first;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// Watchdog on cycles without any beat
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_BITS'(4 * int'(idx));
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_COUNT_MODE: cfg_mode = val[0];
			REG_STRUCT_LIMIT: cfg_limit = val[15:0];
			default: cfg_tlen = val;
		endcase
	endtask

	task automatic set_config(input logic mode, input logic [15:0] limit,
			input logic [31:0] tlen);
		reg_write(REG_COUNT_MODE, 32'(mode));
		reg_write(REG_STRUCT_LIMIT, 32'(limit));
		reg_write(REG_TABLE_LENGTH, tlen);
	endtask

	task automatic set_idling(input int kind);
		case (kind)
			0: begin src_idle_pct = 0; sink_stall_pct = 0; end
			1: begin src_idle_pct = 72; sink_stall_pct = 0; end
			2: begin src_idle_pct = 0; sink_stall_pct = 72; end
			default: begin src_idle_pct = 26; sink_stall_pct = 26; end
		endcase
	endtask

	task automatic push_beat(input bit first, input logic [7:0] b);
		table_beats.push_back({first, b});
	endtask

	// Wait for every queued byte to go in and every record to come out
	task automatic drain();
		bit in_idle;
		forever begin
			@(posedge clk);
			in_idle = (table_beats.size() == 0) && !s_tvalid;
			@(negedge clk);
			if (in_idle && struct_records_due.size() == 0)
				break;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One structure: header, formatted area, string set
	task automatic add_structure(ref table_beat_t q[$], input logic [7:0] stype,
			input int flen);
		int n;
		q.push_back({1'b0, stype});
		q.push_back({1'b0, 8'(flen)});
		q.push_back({1'b0, 8'($urandom)});
		q.push_back({1'b0, 8'($urandom)});
		for (int i = 4; i < flen; i++)
			q.push_back({1'b0, 8'($urandom)});
		n = $urandom_range(0, 3);
		if (n == 0) begin
			q.push_back({1'b0, 8'h00});
		end else begin
			for (int s = 0; s < n; s++) begin
				repeat ($urandom_range(1, 6))
					q.push_back({1'b0, 8'($urandom_range(1, 255))});
				q.push_back({1'b0, 8'h00});
			end
		end
		q.push_back({1'b0, 8'h00});
	endtask

	// Well-formed walk, sometimes without end marker or cut short
	task automatic push_walk();
		table_beat_t wq[$];
		int nst;
		int flen;
		int cut;
		logic [7:0] st;
		nst = $urandom_range(1, 5);
		for (int i = 0; i < nst; i++) begin
			st = 8'($urandom);
			if (st == END_OF_TABLE_TYPE)
				st = END_OF_TABLE_TYPE - 8'd1;
			flen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 16);
			add_structure(wq, st, flen);
		end
		if ($urandom_range(0, 9) != 0)
			add_structure(wq, END_OF_TABLE_TYPE, 4);
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, wq.size() - 1);
			repeat (cut) wq.delete(wq.size() - 1);
		end
		wq[0].first = 1'b1;
		foreach (wq[i])
			table_beats.push_back(wq[i]);
		beats_queued += wq.size();
	endtask

	// Random bytes, zero-heavy, optionally starting a walk
	task automatic push_noise(input bit lead);
		int cnt;
		logic [7:0] b;
		cnt = $urandom_range(1, 30);
		for (int i = 0; i < cnt; i++) begin
			b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
			push_beat(lead && i == 0, b);
		end
		beats_queued += cnt;
	endtask

	initial begin
		logic        mode;
		logic [15:0] limit;
		logic [31:0] tlen;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset registers: stray bytes before a walk, then an empty walk
		set_idling(0);
		push_beat(1'b0, 8'hFF);
		push_beat(1'b0, 8'h00);
		push_beat(1'b1, 8'hA5);
		drain();

		// Count known but zero
		set_config(1'b1, 16'd0, 32'hFFFF_FFFF);
		set_idling(1);
		push_beat(1'b1, 8'h5A);
		drain();

		// Short header, full-range header, end-of-table
		set_config(1'b0, 16'hFFFF, 32'hFFFF_FFFF);
		set_idling(2);
		foreach (MIXED_WALK[i])
			push_beat(i == 0, MIXED_WALK[i]);
		drain();

		// Terminator past the table end
		set_config(1'b1, 16'hFFFF, 32'd6);
		set_idling(3);
		foreach (CUT_WALK[i])
			push_beat(i == 0, CUT_WALK[i]);
		drain();

		// Random phases
		for (int p = 0; p < 14; p++) begin
			mode = $urandom_range(0, 1);
			case ($urandom_range(0, 9))
				0: limit = 16'd0;
				1: limit = 16'hFFFF;
				default: limit = 16'($urandom_range(1, 10));
			endcase
			case ($urandom_range(0, 9))
				0: tlen = 32'($urandom_range(0, 4));
				1: tlen = 32'hFFFF_FFFF;
				2: tlen = $urandom;
				default: tlen = 32'($urandom_range(8, 150));
			endcase
			set_config(mode, limit, tlen);
			set_idling(p % 4);
			beats_queued = 0;
			while (beats_queued < 50) begin
				case ($urandom_range(0, 9))
					0: push_noise(1'b1);
					1: push_noise(1'b0);
					default: push_walk();
				endcase
			end
			drain();
		end

		if (!mismatch_seen && struct_records_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[smbios_structure_walker.f]
rtl/ssw_pkg.sv
rtl/ssw_cfg_regs.sv
rtl/ssw_walk_core.sv
rtl/smbios_structure_walker.sv
verif/smbios_structure_walker_tb.sv
